// ===== hdl/wets_pkg.sv =====
// ----------------------------------------------------------------------------
// wets_pkg: shared types and constants of the weekly event table scheduler
// Transfer payloads, the stored event record and the day match rule.
// ----------------------------------------------------------------------------
package wets_pkg;

  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  localparam logic [3:0] DAY_SUN      = 4'd0;
  localparam logic [3:0] DAY_MON      = 4'd1;
  localparam logic [3:0] DAY_FRI      = 4'd5;
  localparam logic [3:0] DAY_SAT      = 4'd6;
  localparam logic [3:0] DAY_EVERY    = 4'd7;
  localparam logic [3:0] DAY_WEEKDAYS = 4'd8;
  localparam logic [3:0] DAY_WEEKEND  = 4'd9;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  light_id;
    logic [3:0]  day_code;
    logic [10:0] minute_of_day;
    logic        action;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_light_id;
    logic       out_action;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        action;
    logic [10:0] minute;
    logic [3:0]  day;
    logic [7:0]  light;
  } entry_rec_t;

  typedef struct packed {
    logic shift;
    logic ins;
  } cell_ctl_t;

  function automatic logic day_match(logic [3:0] entry_day, logic [3:0] now_day);
    logic wkend;
    logic wkday;
    wkend = now_day inside {DAY_SUN, DAY_SAT};
    wkday = now_day inside {[DAY_MON:DAY_FRI]};
    return (entry_day == DAY_EVERY) || ((entry_day == DAY_WEEKEND) && wkend) ||
           ((entry_day == DAY_WEEKDAYS) && wkday) || (entry_day == now_day);
  endfunction

endpackage

// ===== hdl/wets_cell.sv =====
// ----------------------------------------------------------------------------
// wets_cell: one table entry of the event ring
// Holds a used flag and a record; rotates to its neighbour or loads a new event.
// ----------------------------------------------------------------------------
module wets_cell
  import wets_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  entry_rec_t ins_rec_i,
  input  logic       prev_used_i,
  input  logic       nxt_used_i,
  input  entry_rec_t nxt_rec_i,
  output logic       used_o,
  output entry_rec_t rec_o
);

  logic       used_q, used_d;
  entry_rec_t rec_q, rec_d;
  logic       load;

  assign load = ctl_i.ins && !used_q && prev_used_i;

  always_comb begin
    used_d = used_q;
    rec_d  = rec_q;
    if (ctl_i.shift) begin
      used_d = nxt_used_i;
      rec_d  = nxt_rec_i;
    end else if (load) begin
      used_d = 1'b1;
      rec_d  = ins_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign used_o = used_q;
  assign rec_o  = rec_q;

endmodule

// ===== hdl/wets_scan.sv =====
// ----------------------------------------------------------------------------
// wets_scan: request sequencer and match stage
// Accepts requests, rotates the ring once per tick, checks the head entry and
// holds one pending match so the final one can carry the last flag.
// ----------------------------------------------------------------------------
module wets_scan
  import wets_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       head_used_i,
  input  entry_rec_t head_rec_i,
  output cell_ctl_t  ctl_o,
  output entry_rec_t ins_rec_o
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [3:0]    day_q, day_d;
  logic [10:0]   min_q, min_d;
  logic          pend_v_q, pend_v_d;
  out_item_t     pend_q, pend_d;
  logic          out_v_q, out_v_d;
  out_item_t     out_q, out_d;

  logic in_fire, hit, out_free, shift;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_v_q || out_ready_i;
  assign hit        = head_used_i && (head_rec_i.minute == min_q) &&
                      day_match(head_rec_i.day, day_q);
  assign shift      = (state_q == ST_SCAN) && !(hit && pend_v_q && !out_free);

  assign ctl_o.shift = shift;
  assign ctl_o.ins   = in_fire && (in_data_i.req_type == REQ_SCHEDULE);
  assign ins_rec_o   = '{action: in_data_i.action, minute: in_data_i.minute_of_day,
                         day: in_data_i.day_code, light: in_data_i.light_id};

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    day_d    = day_q;
    min_d    = min_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_data_i.req_type == REQ_TICK)) begin
          state_d = ST_SCAN;
          step_d  = '0;
          day_d   = in_data_i.day_code;
          min_d   = in_data_i.minute_of_day;
        end
      end
      ST_SCAN: begin
        if (shift) begin
          if (hit) begin
            if (pend_v_q) begin
              out_v_d = 1'b1;
              out_d   = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = '{out_light_id: head_rec_i.light, out_action: head_rec_i.action,
                         last: 1'b0};
          end
          if (step_q == LAST_STEP) begin
            state_d = ST_FLUSH;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d  = 1'b1;
          out_d    = pend_q;
          out_d.last = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    min_q  <= min_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending match held while idle");

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.req_type == REQ_TICK)) |=> (state_q == ST_SCAN && step_q == '0))
    else $error("tick transfer did not start a scan");

  a_stall_holds_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !shift) |=> (state_q == ST_SCAN && $stable(step_q)))
    else $error("scan advanced while stalled");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && pend_v_q && out_free) |=>
      (out_valid_o && out_data_o.last && state_q == ST_IDLE))
    else $error("final match not sent with last");

  a_no_insert_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> !ctl_o.ins)
    else $error("insert during rotation");
`endif

endmodule

// ===== hdl/weekly_event_table_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// weekly_event_table_scheduler_core: light event scheduler, top level
// Ring of event cells plus a sequencer that stores events and scans on ticks.
//
//   channel | direction | payload    | transfer when
//   in      | input     | in_item_t  | in_valid_i && in_ready_o
//   out     | output    | out_item_t | out_valid_o && out_ready_i
//
// A schedule transfer is stored into the first free cell.
// A tick rotates the ring through all TABLE_DEPTH entries and then flushes,
// one head entry checked per cycle unless an output stall holds the ring.
// Reset frees all entries at once; no clearing pass.
// in_ready_o is low for the whole of a tick scan.
// ----------------------------------------------------------------------------
module weekly_event_table_scheduler_core
  import wets_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic       used [TABLE_DEPTH];
  entry_rec_t rec  [TABLE_DEPTH];
  cell_ctl_t  ctl;
  entry_rec_t ins_rec;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % TABLE_DEPTH;
    logic prev_used;
    if (i == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_rest
      assign prev_used = used[i-1];
    end
    wets_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .ins_rec_i   (ins_rec),
      .prev_used_i (prev_used),
      .nxt_used_i  (used[NXT]),
      .nxt_rec_i   (rec[NXT]),
      .used_o      (used[i]),
      .rec_o       (rec[i])
    );
  end

  wets_scan #(
    .DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .head_used_i (used[0]),
    .head_rec_i  (rec[0]),
    .ctl_o       (ctl),
    .ins_rec_o   (ins_rec)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the weekly event table scheduler
// Drives schedule and tick transfers with random idling on both channels and
// keeps its own copy of the event table. Each tick is scanned in table order
// to build the due events in sequence, and every result transfer is checked
// field by field against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wets_pkg::*;

  localparam int DEPTH       = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  logic       slot_used [DEPTH];
  entry_rec_t slot_rec [DEPTH];
  int         slots_taken;
  out_item_t  due_events_q [$];
  int         err_cnt;
  int         cycle_cnt;
  bit         quiet_mode;
  bit         hold_req;
  logic [10:0] minute_pool [8];

  weekly_event_table_scheduler_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit day_is_due(logic [3:0] rec_day, logic [3:0] tick_day);
    case (rec_day)
      DAY_EVERY: begin
        return 1'b1;
      end
      DAY_WEEKDAYS: begin
        return (tick_day == rec_day) || ((tick_day >= DAY_MON) && (tick_day <= DAY_FRI));
      end
      DAY_WEEKEND: begin
        return (tick_day == rec_day) || (tick_day == DAY_SUN) || (tick_day == DAY_SAT);
      end
      default: begin
        return rec_day == tick_day;
      end
    endcase
  endfunction

  function automatic bit slot_is_due(int idx, in_item_t it);
    return slot_used[idx] && (slot_rec[idx].minute == it.minute_of_day) &&
           day_is_due(slot_rec[idx].day, it.day_code);
  endfunction

  function automatic void predict_request(in_item_t it);
    int n_due;
    int k;
    out_item_t hit;
    if (it.req_type == REQ_SCHEDULE) begin
      // first free slot only; drop when full
      if (slots_taken < DEPTH) begin
        slot_rec[slots_taken].light  = it.light_id;
        slot_rec[slots_taken].day    = it.day_code;
        slot_rec[slots_taken].minute = it.minute_of_day;
        slot_rec[slots_taken].action = it.action;
        slot_used[slots_taken]       = 1'b1;
        slots_taken++;
      end
      return;
    end
    n_due = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_is_due(i, it)) n_due++;
    end
    k = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_is_due(i, it)) begin
        k++;
        hit.out_light_id = slot_rec[i].light;
        hit.out_action   = slot_rec[i].action;
        hit.last         = (k == n_due);
        due_events_q.push_back(hit);
      end
    end
  endfunction

  function automatic in_item_t make_item(logic req, logic [7:0] light, logic [3:0] day,
                                         logic [10:0] minute, logic act);
    in_item_t it;
    it.req_type      = req;
    it.light_id      = light;
    it.day_code      = day;
    it.minute_of_day = minute;
    it.action        = act;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_data_i  = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(it);
    @(negedge clk_i);
    if (!quiet_mode && ($urandom_range(0, 3) == 0)) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (due_events_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_item_t rand_tick();
    logic [10:0] minute;
    logic [3:0]  day;
    if ((slots_taken > 0) && ($urandom_range(0, 4) != 0))
      minute = slot_rec[$urandom_range(0, slots_taken - 1)].minute;
    else
      minute = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 6) != 0) day = 4'($urandom_range(0, 6));
    else day = 4'($urandom_range(7, 15));
    return make_item(REQ_TICK, 8'($urandom_range(0, 255)), day, minute,
                     1'($urandom_range(0, 1)));
  endfunction

  function automatic in_item_t rand_schedule();
    logic [10:0] minute;
    logic [3:0]  day;
    if ($urandom_range(0, 9) < 7) minute = minute_pool[$urandom_range(0, 7)];
    else minute = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 6) != 0) day = 4'($urandom_range(0, 9));
    else day = 4'($urandom_range(10, 15));
    return make_item(REQ_SCHEDULE, 8'($urandom_range(0, 255)), day, minute,
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic test_empty_table_tick();
    send_item(make_item(REQ_TICK, 8'hFF, DAY_SUN, 11'd0, 1'b1));
    send_item(make_item(REQ_TICK, 8'h00, DAY_EVERY, 11'd2047, 1'b0));
    wait_drained();
  endtask

  task automatic test_day_rules();
    send_item(make_item(REQ_SCHEDULE, 8'h00, DAY_SUN, 11'd0, 1'b0));
    send_item(make_item(REQ_SCHEDULE, 8'hFF, DAY_SAT, 11'd1439, 1'b1));
    send_item(make_item(REQ_SCHEDULE, 8'hA5, DAY_EVERY, 11'd2047, 1'b1));
    send_item(make_item(REQ_SCHEDULE, 8'h5A, DAY_WEEKDAYS, 11'd1440, 1'b0));
    send_item(make_item(REQ_SCHEDULE, 8'h3C, DAY_WEEKEND, 11'd1439, 1'b1));
    send_item(make_item(REQ_SCHEDULE, 8'h11, 4'd15, 11'd1439, 1'b0));
    send_item(make_item(REQ_SCHEDULE, 8'h22, 4'd10, 11'd0, 1'b1));
    send_item(make_item(REQ_TICK, 8'h00, DAY_SAT, 11'd1439, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_SUN, 11'd0, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_MON, 11'd1440, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_FRI, 11'd1440, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_SAT, 11'd1440, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, 4'd15, 11'd1439, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, 4'd10, 11'd0, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, 4'd12, 11'd2047, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_SUN, 11'd2047, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_WEEKEND, 11'd1439, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_WEEKDAYS, 11'd1440, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_EVERY, 11'd2047, 1'b0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int n_sent;
    n_sent = 0;
    while (n_sent < n_items) begin
      if (slots_taken < DEPTH) begin
        if ($urandom_range(0, 9) < 6) send_item(rand_schedule());
        else send_item(rand_tick());
        n_sent++;
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(rand_schedule());
      end else begin
        send_item(rand_tick());
        n_sent++;
      end
    end
    wait_drained();
  endtask

  task automatic test_table_full();
    while (slots_taken < DEPTH) send_item(rand_schedule());
    send_item(make_item(REQ_SCHEDULE, 8'h77, DAY_EVERY, 11'd1234, 1'b1));
    send_item(make_item(REQ_SCHEDULE, 8'h88, DAY_MON, 11'd1234, 1'b0));
    send_item(make_item(REQ_TICK, 8'h00, DAY_MON, 11'd1234, 1'b0));
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (10) send_item(rand_tick());
    wait_drained();
  endtask

  // receiver side: random stall bursts, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!quiet_mode && ($urandom_range(0, 5) == 0)) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_events_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        err_cnt++;
      end else begin
        want = due_events_q.pop_front();
        if (out_data_o.out_light_id !== want.out_light_id) begin
          $display("%0t: out_light_id expected %0d actual %0d", $time,
                   want.out_light_id, out_data_o.out_light_id);
          err_cnt++;
        end
        if (out_data_o.out_action !== want.out_action) begin
          $display("%0t: out_action expected %0d actual %0d", $time,
                   want.out_action, out_data_o.out_action);
          err_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_data_o.last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    slots_taken = 0;
    quiet_mode  = 1'b0;
    hold_req    = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_rec[i]  = '0;
    end
    minute_pool[0] = 11'd0;
    minute_pool[1] = 11'd1439;
    minute_pool[2] = 11'd1440;
    minute_pool[3] = 11'd2047;
    for (int i = 4; i < 8; i++) minute_pool[i] = 11'($urandom_range(0, 2047));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_table_tick();
    test_day_rules();
    test_random_traffic(140);
    test_table_full();
    test_output_backpressure();
    quiet_mode = 1'b1;
    test_random_traffic(50);

    wait_drained();
    repeat (DEPTH + 16) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
